### sv/assert_macros.svh
// Assertion macros shared by the RTL of the Gaussian normal displacement block.
// Needs a clock named aclk and an active-low synchronous reset named aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GND_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GND_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/gnd_pkg.sv
// Types and constants of the Gaussian normal displacement block.
// Used by gaussian_normal_displace; depends on nothing else.
package gnd_pkg;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [35:0] A_LIMIT = 36'hC_0000_0000;
    localparam int          TERMS   = 13;
    localparam int          N_MAX   = 17;

    localparam logic [7:0] REG_CENTRE_X    = 8'd0;
    localparam logic [7:0] REG_CENTRE_Y    = 8'd1;
    localparam logic [7:0] REG_CENTRE_Z    = 8'd2;
    localparam logic [7:0] REG_GAUSS_COEFF = 8'd3;
    localparam logic [7:0] REG_AMPLITUDE   = 8'd4;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } vtx_t;

    // Carried through the exponential series.
    typedef struct packed {
        logic [31:0] r;
        logic [4:0]  n;
        logic        far;
    } hc_t;

endpackage

### sv/gaussian_normal_displace.sv
// Gaussian normal displacement: moves each vertex along its normal by a Gaussian bump.
// Depends on gnd_pkg and assert_macros.svh.
//
// Usage:
//   Input stream s_*: one vertex per transfer, position Q16.16 and normal Q1.14.
//   Output stream m_*: the displaced position per vertex, with a saturation flag
//   in m_tuser. Configuration channel cfg_*: register index and 32-bit data,
//   always ready; write only while no vertex is in flight.
//   Throughput is one vertex per cycle unless the output stalls. The 13-term
//   exponential series has three register stages per term (product,
//   reciprocal multiply, correction).
//   The whole pipeline advances together; when the receiver holds m_tready low
//   with a result waiting, every stage holds and s_tready drops, so nothing is
//   lost or repeated. Bubbles travel with the data as cleared valid bits.
//   Reset (aresetn low at a clock edge) clears all valid bits and sets every
//   configuration register to zero.
`include "assert_macros.svh"

module gaussian_normal_displace (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // point_x, point_y, point_z, normal_x, normal_y, normal_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // moved_x, moved_y, moved_z
    output logic [0:0]   m_tuser,   // clipped
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int DEPTH = 51;
    localparam int HB    = 8;            // first stage of the series
    localparam int WS    = HB + 3 * gnd_pkg::TERMS;

    logic                     en;
    logic [DEPTH-1:0]         vld_reg;
    gnd_pkg::vtx_t            side_reg [0:DEPTH-2];

    logic signed [31:0]       centre_reg [0:2];
    logic [31:0]              coeff_reg;
    logic signed [31:0]       ampl_reg;

    logic [31:0]              u_reg   [0:2];
    logic [63:0]              sq_reg  [0:2];
    logic [65:0]              sum_reg;
    logic [33:0]              t_reg;
    logic [63:0]              m_reg;
    logic [31:0]              f_reg;
    logic [35:0]              a_reg;
    logic [35:0]              a7_reg;
    logic [4:0]               n_reg;
    gnd_pkg::hc_t             hc_reg;

    logic [31:0]              x_reg  [0:gnd_pkg::TERMS-1];
    logic [31:0]              q0_reg [0:gnd_pkg::TERMS-1];
    logic [31:0]              xq_reg [0:gnd_pkg::TERMS-1];
    logic [32:0]              p_reg  [0:gnd_pkg::TERMS-1];
    gnd_pkg::hc_t             hx_reg [0:gnd_pkg::TERMS-1];
    gnd_pkg::hc_t             hq_reg [0:gnd_pkg::TERMS-1];
    gnd_pkg::hc_t             hp_reg [0:gnd_pkg::TERMS-1];

    logic [16:0]              w_reg;
    logic signed [49:0]       aw_reg;
    logic signed [63:0]       prod_reg [0:2];
    logic [95:0]              out_reg;
    logic                     clip_reg;

    assign en        = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[DEPTH-1];
    assign m_tdata   = out_reg;
    assign m_tuser   = clip_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_reg[0] <= '0;
            centre_reg[1] <= '0;
            centre_reg[2] <= '0;
            coeff_reg     <= '0;
            ampl_reg      <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gnd_pkg::REG_CENTRE_X:    centre_reg[0] <= cfg_data;
                gnd_pkg::REG_CENTRE_Y:    centre_reg[1] <= cfg_data;
                gnd_pkg::REG_CENTRE_Z:    centre_reg[2] <= cfg_data;
                gnd_pkg::REG_GAUSS_COEFF: coeff_reg     <= cfg_data;
                gnd_pkg::REG_AMPLITUDE:   ampl_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0].px <= s_tdata[31:0];
            side_reg[0].py <= s_tdata[63:32];
            side_reg[0].pz <= s_tdata[95:64];
            side_reg[0].nx <= s_tdata[111:96];
            side_reg[0].ny <= s_tdata[127:112];
            side_reg[0].nz <= s_tdata[143:128];
            for (int i = 1; i < DEPTH - 1; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Distance, squares and their sum.
    logic signed [31:0] pos1 [0:2];
    logic signed [32:0] d1   [0:2];
    logic [32:0]        ad1  [0:2];

    always_comb begin
        pos1[0] = side_reg[0].px;
        pos1[1] = side_reg[0].py;
        pos1[2] = side_reg[0].pz;
        for (int i = 0; i < 3; i++) begin
            d1[i]  = 33'(pos1[i]) - 33'(centre_reg[i]);
            ad1[i] = d1[i][32] ? 33'(-d1[i]) : 33'(d1[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i]  <= ad1[i][31:0];
                sq_reg[i] <= u_reg[i] * u_reg[i];
            end
            sum_reg <= 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
        end
    end

    // Argument a = coeff * d^2, in Q.32 and saturated at 12.
    logic [63:0] flo5;
    logic [37:0] s6;
    logic        sat6;
    logic [4:0]  n7;
    logic [35:0] nl8;

    always_comb begin
        flo5 = coeff_reg * sum_reg[31:0];
        sat6 = (t_reg >= 34'd12) || (36'(m_reg) >= gnd_pkg::A_LIMIT) || (m_reg[63:36] != '0);
        s6   = {t_reg[3:0], 32'b0} + 38'(m_reg[35:0]) + 38'(f_reg);
        n7   = '0;
        for (int k = 1; k <= gnd_pkg::N_MAX; k++) begin
            if (a_reg >= 36'(k) * 36'(gnd_pkg::LN2_Q32)) begin
                n7 = n7 + 5'd1;
            end
        end
        nl8 = 36'(n_reg) * 36'(gnd_pkg::LN2_Q32);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg  <= coeff_reg * 34'(sum_reg[65:64]);
            m_reg  <= coeff_reg * sum_reg[63:32];
            f_reg  <= flo5[63:32];
            if (sat6 || s6 >= 38'(gnd_pkg::A_LIMIT)) begin
                a_reg <= gnd_pkg::A_LIMIT;
            end else begin
                a_reg <= s6[35:0];
            end
            a7_reg     <= a_reg;
            n_reg      <= n7;
            hc_reg.r   <= 32'(a7_reg - nl8);
            hc_reg.n   <= n_reg;
            hc_reg.far <= a7_reg >= gnd_pkg::A_LIMIT;
        end
    end

    // Horner steps of exp(-r), highest term first.
    for (genvar j = 0; j < gnd_pkg::TERMS; j++) begin : g_term
        localparam int          K = gnd_pkg::TERMS - j;
        localparam logic [34:0] R = 35'((64'd1 << 34) / K);
        logic [32:0]  p_in;
        gnd_pkg::hc_t h_in;
        logic [64:0]  rp;
        logic [66:0]  xr;
        logic [31:0]  q0k;
        logic [31:0]  rem;
        logic [31:0]  q;

        if (j == 0) begin : g_first
            assign p_in = gnd_pkg::ONE_Q32;
            assign h_in = hc_reg;
        end else begin : g_next
            assign p_in = p_reg[j-1];
            assign h_in = hp_reg[j-1];
        end

        assign rp  = 65'(h_in.r) * 65'(p_in);
        assign xr  = 67'(x_reg[j]) * 67'(R);
        assign q0k = 32'(q0_reg[j] * 32'(K));
        assign rem = xq_reg[j] - q0k;
        assign q   = (rem >= 32'(K)) ? q0_reg[j] + 32'd1 : q0_reg[j];

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[j]  <= rp[63:32];
                hx_reg[j] <= h_in;
                q0_reg[j] <= xr[65:34];
                xq_reg[j] <= x_reg[j];
                hq_reg[j] <= hx_reg[j];
                p_reg[j]  <= gnd_pkg::ONE_Q32 - 33'(q);
                hp_reg[j] <= hq_reg[j];
            end
        end
    end

    // Weight, amplitude product and per-axis displacement.
    localparam int LT = gnd_pkg::TERMS - 1;
    logic [33:0]        wsum;
    logic [33:0]        wsh;
    logic signed [15:0] nrm [0:2];
    logic signed [31:0] pos [0:2];
    logic signed [63:0] rnd [0:2];
    logic signed [35:0] mv  [0:2];
    logic [31:0]        res [0:2];
    logic [2:0]         clp;

    always_comb begin
        wsum   = 34'(p_reg[LT]) + (34'd1 << (6'(hp_reg[LT].n) + 6'd15));
        wsh    = wsum >> (6'(hp_reg[LT].n) + 6'd16);
        nrm[0] = side_reg[DEPTH-3].nx;
        nrm[1] = side_reg[DEPTH-3].ny;
        nrm[2] = side_reg[DEPTH-3].nz;
        pos[0] = side_reg[DEPTH-2].px;
        pos[1] = side_reg[DEPTH-2].py;
        pos[2] = side_reg[DEPTH-2].pz;
        for (int i = 0; i < 3; i++) begin
            rnd[i] = (prod_reg[i] + (64'sd1 <<< 29)) >>> 30;
            mv[i]  = 36'(pos[i]) + 36'(rnd[i]);
            if (mv[i] > 36'sh0_7FFF_FFFF) begin
                res[i] = 32'h7FFF_FFFF;
                clp[i] = 1'b1;
            end else if (mv[i] < -36'sh0_8000_0000) begin
                res[i] = 32'h8000_0000;
                clp[i] = 1'b1;
            end else begin
                res[i] = mv[i][31:0];
                clp[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg    <= hp_reg[LT].far ? 17'd0 : wsh[16:0];
            aw_reg   <= ampl_reg * $signed({1'b0, w_reg});
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= 64'(aw_reg) * 64'(nrm[i]);
            end
            out_reg  <= {res[2], res[1], res[0]};
            clip_reg <= |clp;
        end
    end

    `GND_ASSERT_IMP(a_arg_limit, vld_reg[5], a_reg <= gnd_pkg::A_LIMIT, "argument beyond limit")
    `GND_ASSERT_IMP(a_n_range, vld_reg[6], n_reg <= 5'(gnd_pkg::N_MAX), "ln2 multiple out of range")
    `GND_ASSERT_IMP(a_weight_max, vld_reg[WS], w_reg <= 17'd65536, "weight above one")
    `GND_ASSERT_NXT(a_advance, en && vld_reg[HB], vld_reg[HB+1], "item lost in series")
    `GND_ASSERT_IMP(a_clip_value, m_tvalid && m_tuser[0],
        m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
        m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000 ||
        m_tdata[95:64] == 32'h7FFF_FFFF || m_tdata[95:64] == 32'h8000_0000,
        "clipped without a saturated coordinate")

endmodule
